### rtl/rmq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: shared package
// Types, constants and arithmetic step functions used by the front end,
// the queue and the pipelined back end.
// ----------------------------------------------------------------------------
package rmq_pkg;

  localparam int SQ_STEPS   = 17;  // root bits, one per square-root stage
  localparam int DIV_STEPS  = 17;  // quotient bits, one per divider stage
  localparam int LANES      = 3;   // divided components per item
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic signed [17:0] QONE = 18'sd16384;

  // Which component takes the square root directly.
  typedef enum logic [1:0] {
    BR_TRACE,
    BR_X,
    BR_Y,
    BR_Z
  } br_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m02;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [15:0] m12;
    logic signed [15:0] m20;
    logic signed [15:0] m21;
    logic signed [15:0] m22;
  } in_t;

  typedef struct packed {
    logic signed [15:0] quat_x;
    logic signed [15:0] quat_y;
    logic signed [15:0] quat_z;
    logic        [14:0] quat_w;
  } out_t;

  // Classified item. The three numerators are the non-root components in
  // the order x, y, z, w with the root component left out.
  typedef struct packed {
    br_t                br;
    logic signed [17:0] rad;
    logic signed [16:0] n0;
    logic signed [16:0] n1;
    logic signed [16:0] n2;
  } cls_t;

  typedef struct packed {
    br_t                br;
    logic signed [16:0] n0;
    logic signed [16:0] n1;
    logic signed [16:0] n2;
  } pay_t;

  // One divider lane: partial remainder, dividend bits still to bring in,
  // quotient so far and the flags for the final fix-up.
  typedef struct packed {
    logic [16:0] rem;
    logic [16:0] low;
    logic [16:0] q;
    logic        neg;
    logic        zero;
    logic        ovf;
  } lane_t;

  // Set up a lane: magnitude times 16384 plus half the root, with an
  // overflow flag when the quotient would not fit in 17 bits.
  function automatic lane_t lane_init(logic signed [16:0] n, logic [16:0] r);
    logic [16:0] nabs;
    logic [30:0] dvd;
    lane_t       l;
    nabs   = n[16] ? 17'(-n) : 17'(n);
    dvd    = {nabs, 14'b0} + {15'b0, r[16:1]};
    l.rem  = {3'b0, dvd[30:17]};
    l.low  = dvd[16:0];
    l.q    = '0;
    l.neg  = n[16];
    l.zero = (nabs == 17'd0);
    l.ovf  = ({3'b0, dvd[30:17]} >= r);
    return l;
  endfunction

  // One restoring division step.
  function automatic lane_t lane_step(lane_t l, logic [16:0] r);
    logic [17:0] sh;
    logic [17:0] diff;
    logic        ge;
    lane_t       o;
    sh     = {l.rem, l.low[16]};
    diff   = sh - {1'b0, r};
    ge     = (sh >= {1'b0, r});
    o      = l;
    o.rem  = ge ? diff[16:0] : sh[16:0];
    o.low  = {l.low[15:0], 1'b0};
    o.q    = {l.q[15:0], ge};
    return o;
  endfunction

  // Signed value of a finished lane; a huge quotient is kept clear of
  // the output range so that saturation still applies after a flip.
  function automatic logic signed [18:0] lane_val(lane_t l);
    logic [16:0] mag;
    logic [18:0] ext;
    mag = l.zero ? 17'd0 : (l.ovf ? 17'h1FFFF : l.q);
    ext = {2'b0, mag};
    return l.neg ? 19'(-ext) : 19'(ext);
  endfunction

  function automatic logic signed [15:0] sat16(logic signed [18:0] v);
    logic signed [15:0] s;
    if (v > 19'sd32767) begin
      s = 16'sh7FFF;
    end else if (v < -19'sd32768) begin
      s = 16'sh8000;
    end else begin
      s = v[15:0];
    end
    return s;
  endfunction

endpackage

### rtl/rotation_matrix_to_quaternion_top.sv
`timescale 1ns / 1ps
// Throughput: one matrix per cycle while the output is not stalled;
// the 17-stage square root and the three 17-stage dividers are fully
// pipelined, one bit per stage. A four-entry queue lets the input side
// keep accepting while output stalls, until the queue is full.
// Reset (rst_n low, synchronous) empties the pipeline and the queue.
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: top level
// Converts a Q1.14 rotation matrix to a unit quaternion with w not negative.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rmq_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output rmq_pkg::out_t out_data
);
  import rmq_pkg::*;

  logic cls_valid;
  cls_t cls_data;
  logic q_full;
  logic q_empty;
  logic q_pop;
  cls_t q_data;

  rmq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cls_valid (cls_valid),
    .cls_full  (q_full),
    .cls_data  (cls_data)
  );

  rmq_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (cls_valid),
    .push_data (cls_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_data),
    .empty     (q_empty)
  );

  rmq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_data    (q_data),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

### rtl/rmq_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: front end
// Accepts matrix beats, picks the branch and forms the radicand and the
// three numerators, and hands classified items to the queue.
// ----------------------------------------------------------------------------
module rmq_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  rmq_pkg::in_t  in_data,
  output logic          cls_valid,
  input  logic          cls_full,
  output rmq_pkg::cls_t cls_data
);
  import rmq_pkg::*;

  logic               vld_r;
  logic               vld_nxt;
  cls_t               cls_r;
  cls_t               cls_nxt;
  logic               push;
  logic               acc;
  logic signed [17:0] trace;
  logic signed [16:0] a00, a01, a02, a10, a11, a12, a20, a21, a22;

  assign push     = vld_r && !cls_full;
  assign in_stall = vld_r && cls_full;
  assign acc      = in_valid && !in_stall;

  // Sign-extend the entries once for the sums.
  assign a00 = 17'(in_data.m00);
  assign a01 = 17'(in_data.m01);
  assign a02 = 17'(in_data.m02);
  assign a10 = 17'(in_data.m10);
  assign a11 = 17'(in_data.m11);
  assign a12 = 17'(in_data.m12);
  assign a20 = 17'(in_data.m20);
  assign a21 = 17'(in_data.m21);
  assign a22 = 17'(in_data.m22);
  assign trace = 18'(a00) + 18'(a11) + 18'(a22);

  // Branch choice and operand set-up.
  always_comb begin
    priority if (trace > 18'sd0) begin
      cls_nxt.br  = BR_TRACE;
      cls_nxt.rad = QONE + trace;
      cls_nxt.n0  = a21 - a12;
      cls_nxt.n1  = a02 - a20;
      cls_nxt.n2  = a10 - a01;
    end else if (a00 > a11 && a00 > a22) begin
      cls_nxt.br  = BR_X;
      cls_nxt.rad = QONE + 18'(a00) - 18'(a11) - 18'(a22);
      cls_nxt.n0  = a01 + a10;
      cls_nxt.n1  = a02 + a20;
      cls_nxt.n2  = a21 - a12;
    end else if (a11 > a22) begin
      cls_nxt.br  = BR_Y;
      cls_nxt.rad = QONE + 18'(a11) - 18'(a00) - 18'(a22);
      cls_nxt.n0  = a01 + a10;
      cls_nxt.n1  = a12 + a21;
      cls_nxt.n2  = a02 - a20;
    end else begin
      cls_nxt.br  = BR_Z;
      cls_nxt.rad = QONE + 18'(a22) - 18'(a00) - 18'(a11);
      cls_nxt.n0  = a02 + a20;
      cls_nxt.n1  = a12 + a21;
      cls_nxt.n2  = a10 - a01;
    end
  end

  assign vld_nxt = acc || (vld_r && !push);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      cls_r <= cls_nxt;
    end
  end

  assign cls_valid = push;
  assign cls_data  = cls_r;

endmodule

### rtl/rmq_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: item queue
// Short queue of classified items between the front end and the back end.
// ----------------------------------------------------------------------------
module rmq_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rmq_pkg::cls_t push_data,
  output logic          full,
  input  logic          pop,
  output rmq_pkg::cls_t pop_data,
  output logic          empty
);
  import rmq_pkg::*;

  cls_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_AW:0]     cnt_r, cnt_nxt;

  assign full  = (cnt_r == (FIFO_AW+1)'(FIFO_DEPTH));
  assign empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign pop_data = mem_r[rd_ptr_r];

endmodule

### rtl/rmq_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: back end
// Pipelined square root, three pipelined dividers and the final sign fix,
// saturation and output register.
// ----------------------------------------------------------------------------
module rmq_back (
  input  logic          clk,
  input  logic          rst_n,
  input  rmq_pkg::cls_t q_data,
  input  logic          q_empty,
  output logic          q_pop,
  output logic          out_valid,
  input  logic          out_stall,
  output rmq_pkg::out_t out_data
);
  import rmq_pkg::*;

  logic  en;
  logic  pop;

  // Square-root stages.
  logic        sq_vld_r  [SQ_STEPS+1];
  logic [33:0] sq_v_r    [SQ_STEPS+1];
  logic [18:0] sq_rem_r  [SQ_STEPS+1];
  logic [16:0] sq_root_r [SQ_STEPS+1];
  pay_t        sq_pay_r  [SQ_STEPS+1];

  // Divider stages.
  logic        dv_vld_r  [DIV_STEPS+1];
  logic [16:0] dv_root_r [DIV_STEPS+1];
  br_t         dv_br_r   [DIV_STEPS+1];
  lane_t       dv_lane_r [DIV_STEPS+1][LANES];

  logic        out_vld_r;
  out_t        out_r;
  out_t        out_nxt;

  // The whole pipe advances unless a finished beat is held at the output.
  assign en    = !out_vld_r || !out_stall;
  assign pop   = en && !q_empty;
  assign q_pop = pop;

  // Entry stage: a non-positive radicand reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_vld_r[0] <= 1'b0;
    end else if (en) begin
      sq_vld_r[0] <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_v_r[0]      <= (q_data.rad > 18'sd0) ? {1'b0, q_data.rad[16:0], 16'b0} : 34'd0;
      sq_rem_r[0]    <= '0;
      sq_root_r[0]   <= '0;
      sq_pay_r[0].br <= q_data.br;
      sq_pay_r[0].n0 <= q_data.n0;
      sq_pay_r[0].n1 <= q_data.n1;
      sq_pay_r[0].n2 <= q_data.n2;
    end
  end

  // One root bit per stage, two radicand bits brought in each time.
  for (genvar s = 0; s < SQ_STEPS; s++) begin : g_sq
    logic [20:0] remsh;
    logic [20:0] trial;
    logic [20:0] diff;
    logic        ge;

    assign remsh = {sq_rem_r[s], sq_v_r[s][33:32]};
    assign trial = {2'b0, sq_root_r[s], 2'b01};
    assign diff  = remsh - trial;
    assign ge    = (remsh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sq_vld_r[s+1] <= 1'b0;
      end else if (en) begin
        sq_vld_r[s+1] <= sq_vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_v_r[s+1]    <= {sq_v_r[s][31:0], 2'b00};
        sq_rem_r[s+1]  <= ge ? diff[18:0] : remsh[18:0];
        sq_root_r[s+1] <= {sq_root_r[s][15:0], ge};
        sq_pay_r[s+1]  <= sq_pay_r[s];
      end
    end
  end

  // Dividend set-up from the finished root.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_vld_r[0] <= 1'b0;
    end else if (en) begin
      dv_vld_r[0] <= sq_vld_r[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_root_r[0]    <= sq_root_r[SQ_STEPS];
      dv_br_r[0]      <= sq_pay_r[SQ_STEPS].br;
      dv_lane_r[0][0] <= lane_init(sq_pay_r[SQ_STEPS].n0, sq_root_r[SQ_STEPS]);
      dv_lane_r[0][1] <= lane_init(sq_pay_r[SQ_STEPS].n1, sq_root_r[SQ_STEPS]);
      dv_lane_r[0][2] <= lane_init(sq_pay_r[SQ_STEPS].n2, sq_root_r[SQ_STEPS]);
    end
  end

  // One quotient bit per stage in each lane.
  for (genvar s = 0; s < DIV_STEPS; s++) begin : g_dv
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_vld_r[s+1] <= 1'b0;
      end else if (en) begin
        dv_vld_r[s+1] <= dv_vld_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_root_r[s+1] <= dv_root_r[s];
        dv_br_r[s+1]   <= dv_br_r[s];
      end
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      always_ff @(posedge clk) begin
        if (en) begin
          dv_lane_r[s+1][l] <= lane_step(dv_lane_r[s][l], dv_root_r[s]);
        end
      end
    end
  end

  // Final assembly: place components, flip so that w is not negative,
  // then saturate.
  always_comb begin
    logic        [17:0] own_sum;
    logic signed [18:0] own;
    logic signed [18:0] v0, v1, v2;
    logic signed [18:0] qx, qy, qz, qw;
    own_sum = {1'b0, dv_root_r[DIV_STEPS]} + 18'd2;
    own     = {3'b0, own_sum[17:2]};
    v0      = lane_val(dv_lane_r[DIV_STEPS][0]);
    v1      = lane_val(dv_lane_r[DIV_STEPS][1]);
    v2      = lane_val(dv_lane_r[DIV_STEPS][2]);
    unique case (dv_br_r[DIV_STEPS])
      BR_TRACE: begin
        qx = v0; qy = v1; qz = v2; qw = own;
      end
      BR_X: begin
        qx = own; qy = v0; qz = v1; qw = v2;
      end
      BR_Y: begin
        qx = v0; qy = own; qz = v1; qw = v2;
      end
      default: begin
        qx = v0; qy = v1; qz = own; qw = v2;
      end
    endcase
    if (qw[18]) begin
      qx = -qx;
      qy = -qy;
      qz = -qz;
      qw = -qw;
    end
    out_nxt.quat_x = sat16(qx);
    out_nxt.quat_y = sat16(qy);
    out_nxt.quat_z = sat16(qz);
    out_nxt.quat_w = (qw > 19'sd32767) ? 15'h7FFF : qw[14:0];
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

### verif/rotation_matrix_to_quaternion_top_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rotation matrix to quaternion: block testbench
// Drives Q1.14 matrices through the valid/stall input channel, predicts each
// quaternion with an independent integer model of the conversion, and checks
// every output beat field by field in order under random idling on both sides.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_top_tb;

  import rmq_pkg::*;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  in_valid = 1'b0;
  logic  in_stall;
  in_t   in_data = '0;
  logic  out_valid;
  logic  out_stall = 1'b0;
  out_t  out_data;

  out_t  quat_queue[$];
  int    fail_count = 0;
  bit    idle_enable = 1'b1;
  bit    long_hold = 1'b0;

  rotation_matrix_to_quaternion_top i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Clock with a 10 ns period.
  always #5 clk = ~clk;

  // Integer square root of a non-negative value.
  function automatic longint int_sqrt(longint v);
    longint r;
    longint b;
    r = 0;
    b = 64'sd1 <<< 20;
    while (b > 0) begin
      if ((r + b) * (r + b) <= v) begin
        r = r + b;
      end
      b = b >>> 1;
    end
    return r;
  endfunction

  // Root with 15 fraction bits of a radicand with 14; zero when not positive.
  function automatic longint scaled_root(longint t);
    return (t <= 0) ? 0 : int_sqrt(t * 65536);
  endfunction

  // Numerator times one over the root, rounded half away from zero.
  function automatic longint div_root(longint n, longint r);
    longint q;
    if (r == 0) begin
      return (n > 0) ? 64'sd1048576 : ((n < 0) ? -64'sd1048576 : 0);
    end
    q = (((n < 0) ? -n : n) * 16384 + r / 2) / r;
    return (n < 0) ? -q : q;
  endfunction

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  // Expected quaternion for one matrix.
  function automatic out_t predict_quat(in_t m);
    longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
    longint qx, qy, qz, qw, r, tr;
    out_t   q;
    a00 = m.m00; a01 = m.m01; a02 = m.m02;
    a10 = m.m10; a11 = m.m11; a12 = m.m12;
    a20 = m.m20; a21 = m.m21; a22 = m.m22;
    tr = a00 + a11 + a22;
    if (tr > 0) begin
      r  = scaled_root(16384 + tr);
      qw = (r + 2) >>> 2;
      qx = div_root(a21 - a12, r);
      qy = div_root(a02 - a20, r);
      qz = div_root(a10 - a01, r);
    end else if (a00 > a11 && a00 > a22) begin
      r  = scaled_root(16384 + a00 - a11 - a22);
      qw = div_root(a21 - a12, r);
      qx = (r + 2) >>> 2;
      qy = div_root(a01 + a10, r);
      qz = div_root(a02 + a20, r);
    end else if (a11 > a22) begin
      r  = scaled_root(16384 + a11 - a00 - a22);
      qw = div_root(a02 - a20, r);
      qx = div_root(a01 + a10, r);
      qy = (r + 2) >>> 2;
      qz = div_root(a12 + a21, r);
    end else begin
      r  = scaled_root(16384 + a22 - a00 - a11);
      qw = div_root(a10 - a01, r);
      qx = div_root(a02 + a20, r);
      qy = div_root(a12 + a21, r);
      qz = (r + 2) >>> 2;
    end
    // Keep w non-negative by flipping the whole quaternion.
    if (qw < 0) begin
      qx = -qx; qy = -qy; qz = -qz; qw = -qw;
    end
    if (qw > 32767) qw = 32767;
    q.quat_x = clamp16(qx);
    q.quat_y = clamp16(qy);
    q.quat_z = clamp16(qz);
    q.quat_w = qw[14:0];
    return q;
  endfunction

  // Offer one matrix beat and hold it until accepted.
  task automatic send_matrix(in_t m);
    int gap;
    if (idle_enable && $urandom_range(3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(3, 1);
      repeat (gap) @(negedge clk);
    end
    in_data  <= m;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    quat_queue.insert(quat_queue.size(), predict_quat(m));
    @(negedge clk);
  endtask

  task automatic stop_sending();
    in_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [15:0] rand_entry();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'(int'($urandom_range(32768)) - 16384);
      default: return 16'($urandom);
    endcase
  endfunction

  // A proper rotation built from an axis-angle with small rounding noise.
  function automatic in_t rotation_matrix();
    real ax, ay, az, n, th, c, s, t;
    real e[9];
    in_t m;
    ax = $urandom_range(2000) - 1000.0;
    ay = $urandom_range(2000) - 1000.0;
    az = $urandom_range(2000) - 1000.0;
    n = $sqrt(ax * ax + ay * ay + az * az);
    if (n < 1.0) begin
      ax = 1.0; n = 1.0;
    end
    ax = ax / n; ay = ay / n; az = az / n;
    th = $urandom_range(62832) / 10000.0;
    c = $cos(th); s = $sin(th); t = 1.0 - c;
    e[0] = t * ax * ax + c;      e[1] = t * ax * ay - s * az; e[2] = t * ax * az + s * ay;
    e[3] = t * ax * ay + s * az; e[4] = t * ay * ay + c;      e[5] = t * ay * az - s * ax;
    e[6] = t * ax * az - s * ay; e[7] = t * ay * az + s * ax; e[8] = t * az * az + c;
    m.m00 = 16'($rtoi(e[0] * 16384.0) + int'($urandom_range(4)) - 2);
    m.m01 = 16'($rtoi(e[1] * 16384.0) + int'($urandom_range(4)) - 2);
    m.m02 = 16'($rtoi(e[2] * 16384.0) + int'($urandom_range(4)) - 2);
    m.m10 = 16'($rtoi(e[3] * 16384.0) + int'($urandom_range(4)) - 2);
    m.m11 = 16'($rtoi(e[4] * 16384.0) + int'($urandom_range(4)) - 2);
    m.m12 = 16'($rtoi(e[5] * 16384.0) + int'($urandom_range(4)) - 2);
    m.m20 = 16'($rtoi(e[6] * 16384.0) + int'($urandom_range(4)) - 2);
    m.m21 = 16'($rtoi(e[7] * 16384.0) + int'($urandom_range(4)) - 2);
    m.m22 = 16'($rtoi(e[8] * 16384.0) + int'($urandom_range(4)) - 2);
    return m;
  endfunction

  function automatic in_t noise_matrix();
    in_t m;
    m.m00 = rand_entry(); m.m01 = rand_entry(); m.m02 = rand_entry();
    m.m10 = rand_entry(); m.m11 = rand_entry(); m.m12 = rand_entry();
    m.m20 = rand_entry(); m.m21 = rand_entry(); m.m22 = rand_entry();
    return m;
  endfunction

  function automatic in_t diag_matrix(int d0, int d1, int d2, int off);
    in_t m;
    m = '0;
    m.m00 = 16'(d0); m.m11 = 16'(d1); m.m22 = 16'(d2);
    m.m01 = 16'(off); m.m10 = 16'(-off); m.m12 = 16'(off);
    m.m21 = 16'(-2 * off); m.m02 = 16'(off); m.m20 = 16'(off);
    return m;
  endfunction

  // Output-side stall: random bursts, a long hold-off when requested.
  initial begin
    int len;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (200) @(negedge clk);
        out_stall <= 1'b0;
        long_hold = 1'b0;
      end else if (idle_enable && $urandom_range(4) == 0) begin
        len = $urandom_range(3, 1);
        out_stall <= 1'b1;
        repeat (len) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Compare every accepted quaternion beat with the oldest prediction.
  always @(posedge clk) begin
    out_t exp_q;
    if (rst_n && out_valid && !out_stall) begin
      if (quat_queue.size() == 0) begin
        $error("unexpected quaternion beat %h", out_data);
        fail_count++;
      end else begin
        exp_q = quat_queue.pop_front();
        if (out_data.quat_x !== exp_q.quat_x) begin
          $error("quat_x expected %0d actual %0d", exp_q.quat_x, out_data.quat_x);
          fail_count++;
        end
        if (out_data.quat_y !== exp_q.quat_y) begin
          $error("quat_y expected %0d actual %0d", exp_q.quat_y, out_data.quat_y);
          fail_count++;
        end
        if (out_data.quat_z !== exp_q.quat_z) begin
          $error("quat_z expected %0d actual %0d", exp_q.quat_z, out_data.quat_z);
          fail_count++;
        end
        if (out_data.quat_w !== exp_q.quat_w) begin
          $error("quat_w expected %0d actual %0d", exp_q.quat_w, out_data.quat_w);
          fail_count++;
        end
      end
    end
  end

  // Branch selection, invalid radicands, zero roots and extreme codes.
  task automatic test_directed();
    in_t m;
    send_matrix(diag_matrix(16384, 16384, 16384, 0));
    send_matrix(diag_matrix(16384, -16384, -16384, 0));
    send_matrix(diag_matrix(-16384, 16384, -16384, 0));
    send_matrix(diag_matrix(-16384, -16384, 16384, 0));
    send_matrix(diag_matrix(100, 100, 100, 0));
    send_matrix(diag_matrix(0, 0, 0, 500));
    send_matrix(diag_matrix(-5000, -5000, -5000, 3000));
    send_matrix(diag_matrix(-16384, -16384, -16384, 2000));
    send_matrix(diag_matrix(-16384, -16384, -16384, -2000));
    send_matrix(diag_matrix(-32768, -32768, -32768, 7));
    send_matrix(diag_matrix(32767, 32767, 32767, -32768));
    send_matrix(diag_matrix(-32768, 32767, -32768, 32767));
    send_matrix(diag_matrix(32767, -32768, -32768, -32768));
    send_matrix(diag_matrix(-32768, -32768, 32767, 12345));
    send_matrix(diag_matrix(-100, -100, -100, 0));
    send_matrix(diag_matrix(-8192, -8192, -8192, 16384));
    send_matrix(diag_matrix(-200, -200, 0, 1));
    m = '0; m.m12 = 16'h7FFF; m.m21 = 16'h8000; m.m00 = -16'sd16384;
    send_matrix(m);
    m = '1; send_matrix(m);
    m = {9{16'h7FFF}}; send_matrix(m);
    m = {9{16'h8000}}; send_matrix(m);
    m = {9{16'h5555}}; send_matrix(m);
    m = {9{16'hAAAA}}; send_matrix(m);
  endtask

  // Mostly proper rotations, the rest random codes.
  task automatic test_random(int count);
    repeat (count) begin
      send_matrix(($urandom_range(3) == 0) ? noise_matrix() : rotation_matrix());
    end
  endtask

  // Hold the output off while matrices keep coming, to fill the pipeline.
  task automatic test_backpressure();
    long_hold = 1'b1;
    test_random(80);
  endtask

  // Back-to-back traffic with no idling on either side.
  task automatic test_full_rate();
    idle_enable = 1'b0;
    test_random(150);
  endtask

  initial begin
    int waited;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_directed();
    test_random(400);
    test_backpressure();
    test_random(400);
    test_full_rate();
    stop_sending();
    waited = 0;
    while (quat_queue.size() != 0 && waited < 5000) begin
      @(negedge clk);
      waited++;
    end
    repeat (50) @(negedge clk);
    if (fail_count == 0 && quat_queue.size() == 0) begin
      $display("rotation_matrix_to_quaternion_top_tb OK");
    end else begin
      $display("rotation_matrix_to_quaternion_top_tb NOT OK");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2ms;
    $display("rotation_matrix_to_quaternion_top_tb NOT OK");
    $finish;
  end

endmodule
